FILE: rtl/mvc_pkg.sv
// ----------------------------------------------------------------------------
// mvc_pkg
// Shared types, constants and the quarter-wave sine table for the chorus.
// ----------------------------------------------------------------------------
package mvc_pkg;

    localparam int LINE_DEPTH      = 8192;
    localparam int MAX_VOICE_TOTAL = 16;
    localparam int SINE_POINTS     = 1024;

    localparam int SAMPLE_W     = 24;
    localparam int FRAC_W       = 8;
    localparam int LINE_AW      = $clog2(LINE_DEPTH);
    localparam int POS_W        = LINE_AW + FRAC_W;
    localparam int DLY_W        = ((POS_W > 21) ? POS_W : 21) + 2;
    localparam int SINE_AW      = $clog2(SINE_POINTS);
    localparam int QTR_AW       = SINE_AW - 2;
    localparam int QUARTER_POINTS = SINE_POINTS / 4;
    localparam int VOICE_W      = $clog2(MAX_VOICE_TOTAL);
    localparam int VCNT_W       = VOICE_W + 1;
    localparam int SUM_W        = SAMPLE_W + VOICE_W;
    localparam int DIVD_W       = SUM_W + 1;
    localparam int DCNT_W       = $clog2(DIVD_W);
    localparam int MIX_W        = DIVD_W + 18;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic signed [DLY_W-1:0] MAX_DLY = DLY_W'((LINE_DEPTH - 1) * 256);
    localparam logic signed [MIX_W-16:0] SAT_MAX = (MIX_W-15)'(8388607);
    localparam logic signed [MIX_W-16:0] SAT_MIN = -(MIX_W-15)'(8388608);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_DELAY  = 3'd0,
        REG_MOD_DEPTH   = 3'd1,
        REG_PHASE_STEP  = 3'd2,
        REG_WET_MIX     = 3'd3,
        REG_VOICE_COUNT = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } mvc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } mvc_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PHASE,
        ST_DELAY,
        ST_READ_A,
        ST_READ_B,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_WET,
        ST_MIX,
        ST_PUT
    } mvc_state_t;

    typedef struct packed {
        logic clr_wr;
        logic line_wr;
        logic sine_ld;
        logic dly_ld;
        logic rd_a;
        logic rd_b;
        logic accum;
        logic div_ld;
        logic div_step;
        logic wet_ld;
        logic mix_fin;
        logic side_next;
        logic out_ld;
    } mvc_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last_voice;
        logic div_last;
        logic side;
        logic out_free;
    } mvc_status_t;

    typedef logic [15:0] sine_tab_t [0:QUARTER_POINTS];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

    // Integer Taylor series in Q30, rounded to Q15; evaluated at elaboration.
    function automatic sine_tab_t build_sine();
        sine_tab_t        tab;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint           sum;
        longint           q;
        for (int k = 0; k <= QUARTER_POINTS; k++)
        begin
            x    = (HALF_PI_Q30 * longint'(k) + QUARTER_POINTS / 2) / QUARTER_POINTS;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            q = (sum + (64'sd1 <<< 14)) >>> 15;
            if (q < 0)
                q = 0;
            if (q > 32768)
                q = 32768;
            tab[k] = 16'(q);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    function automatic logic [31:0] phase_init(input int v);
        return 32'((64'(v) << 32) / MAX_VOICE_TOTAL);
    endfunction

endpackage

FILE: rtl/mvc_ram.sv
// ----------------------------------------------------------------------------
// mvc_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mvc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        else
            rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mvc_ctl.sv
// ----------------------------------------------------------------------------
// mvc_ctl
// Sequencer: clearing pass, per-voice reads, two divisions and the mix.
// ----------------------------------------------------------------------------
module mvc_ctl
    import mvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  mvc_status_t status,
    output mvc_cmd_t    cmd
);

    mvc_state_t state_reg;
    mvc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:     if (in_valid) state_next = ST_PHASE;
            ST_PHASE:    state_next = ST_DELAY;
            ST_DELAY:    state_next = ST_READ_A;
            ST_READ_A:   state_next = ST_READ_B;
            ST_READ_B:   state_next = ST_ACCUM;
            ST_ACCUM:    state_next = status.last_voice ? ST_DIV_LOAD : ST_PHASE;
            ST_DIV_LOAD: state_next = ST_DIV_RUN;
            ST_DIV_RUN:  if (status.div_last) state_next = ST_WET;
            ST_WET:      state_next = ST_MIX;
            ST_MIX:      state_next = status.side ? ST_PUT : ST_DIV_LOAD;
            ST_PUT:      if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:    cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.line_wr = in_valid;
            end
            ST_PHASE:    cmd.sine_ld = 1'b1;
            ST_DELAY:    cmd.dly_ld = 1'b1;
            ST_READ_A:   cmd.rd_a = 1'b1;
            ST_READ_B:   cmd.rd_b = 1'b1;
            ST_ACCUM:    cmd.accum = 1'b1;
            ST_DIV_LOAD: cmd.div_ld = 1'b1;
            ST_DIV_RUN:  cmd.div_step = 1'b1;
            ST_WET:      cmd.wet_ld = 1'b1;
            ST_MIX:
            begin
                cmd.mix_fin   = 1'b1;
                cmd.side_next = !status.side;
            end
            ST_PUT:      cmd.out_ld = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

FILE: rtl/mvc_dp.sv
// ----------------------------------------------------------------------------
// mvc_dp
// Datapath: settings, delay lines, voice phases, interpolation, divider, mix.
// ----------------------------------------------------------------------------
module mvc_dp
    import mvc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  mvc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mvc_out_t              out_data,
    input  mvc_cmd_t              cmd,
    output mvc_status_t           status
);

    logic [12:0] center_dly_reg;
    logic [11:0] mod_depth_reg;
    logic [31:0] phase_step_reg;
    logic [15:0] wet_mix_reg;
    logic [4:0]  voice_count_reg;

    logic [31:0]         phase_reg [0:MAX_VOICE_TOTAL-1];
    logic [VOICE_W-1:0]  vidx_reg;
    logic [LINE_AW-1:0]  wp_reg;
    logic [LINE_AW-1:0]  clr_addr_reg;
    logic                side_reg;
    logic                out_valid_reg;
    mvc_out_t            out_data_reg;

    logic signed [SAMPLE_W-1:0] dry_l_reg;
    logic signed [SAMPLE_W-1:0] dry_r_reg;
    logic signed [16:0]         sine_reg;
    logic [POS_W-1:0]           dly_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SUM_W-1:0]    sum_l_reg;
    logic signed [SUM_W-1:0]    sum_r_reg;
    logic [DIVD_W-1:0]          quo_reg;
    logic [VCNT_W-1:0]          rem_reg;
    logic [DCNT_W-1:0]          dcnt_reg;
    logic                       neg_reg;
    logic signed [DIVD_W-1:0]   wet_reg;
    logic signed [MIX_W-1:0]    dry_prod_reg;
    logic signed [SAMPLE_W-1:0] res_l_reg;
    logic signed [SAMPLE_W-1:0] res_r_reg;

    // Effective settings
    logic [VCNT_W-1:0] n_eff;
    logic [15:0]       mix_eff;
    always_comb
    begin
        if ({1'b0, voice_count_reg} < 6'd2)
            n_eff = VCNT_W'(2);
        else if ({1'b0, voice_count_reg} > 6'(MAX_VOICE_TOTAL))
            n_eff = VCNT_W'(MAX_VOICE_TOTAL);
        else
            n_eff = VCNT_W'(voice_count_reg);
        mix_eff = (wet_mix_reg > 16'd32768) ? 16'd32768 : wet_mix_reg;
    end

    // Sine lookup from the current voice's phase
    logic [SINE_AW-1:0] sidx;
    logic [QTR_AW:0]    tidx;
    logic [15:0]        mag;
    logic signed [16:0] sine_val;
    always_comb
    begin
        sidx = phase_reg[vidx_reg][31 -: SINE_AW];
        tidx = sidx[SINE_AW-2] ? ((QTR_AW+1)'(QUARTER_POINTS) - {1'b0, sidx[QTR_AW-1:0]})
                               : {1'b0, sidx[QTR_AW-1:0]};
        mag  = SINE_TAB[tidx];
        sine_val = sidx[SINE_AW-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Delay in Q.8, clamped to the line
    logic signed [29:0]      mod_prod;
    logic signed [DLY_W-1:0] delta;
    logic signed [DLY_W-1:0] dly_sum;
    logic [POS_W-1:0]        dly_clamp;
    always_comb
    begin
        mod_prod = $signed({1'b0, mod_depth_reg}) * sine_reg;
        delta    = DLY_W'(mod_prod >>> 7);
        dly_sum  = $signed(DLY_W'({center_dly_reg, 8'b0})) + delta;
        if (dly_sum < 0)
            dly_clamp = '0;
        else if (dly_sum > MAX_DLY)
            dly_clamp = POS_W'(MAX_DLY);
        else
            dly_clamp = POS_W'(dly_sum);
    end

    // Read point
    logic [POS_W-1:0]   pos;
    logic [LINE_AW-1:0] idx_a;
    logic [LINE_AW-1:0] idx_b;
    logic [FRAC_W-1:0]  frac;
    always_comb
    begin
        pos   = {wp_reg, {FRAC_W{1'b0}}} - dly_reg;
        idx_a = pos[POS_W-1:FRAC_W];
        idx_b = idx_a + 1'b1;
        frac  = pos[FRAC_W-1:0];
    end

    // Delay line memories
    logic                       ram_we;
    logic [LINE_AW-1:0]         ram_addr;
    logic [SAMPLE_W-1:0]        wdata_l;
    logic [SAMPLE_W-1:0]        wdata_r;
    logic [SAMPLE_W-1:0]        rdata_l;
    logic [SAMPLE_W-1:0]        rdata_r;
    logic signed [SAMPLE_W-1:0] rdata;
    always_comb
    begin
        ram_we  = cmd.clr_wr | cmd.line_wr;
        wdata_l = cmd.clr_wr ? '0 : in_data.in_left;
        wdata_r = cmd.clr_wr ? '0 : in_data.in_right;
        priority if (cmd.clr_wr)
            ram_addr = clr_addr_reg;
        else if (cmd.line_wr)
            ram_addr = wp_reg;
        else if (cmd.rd_b)
            ram_addr = idx_b;
        else
            ram_addr = idx_a;
        rdata = $signed(vidx_reg[0] ? rdata_r : rdata_l);
    end

    mvc_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_left_line (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wdata_l),
        .rdata (rdata_l)
    );

    mvc_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_right_line (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wdata_r),
        .rdata (rdata_r)
    );

    // Linear interpolation between a and b
    logic signed [34:0]         interp_sum;
    logic signed [SAMPLE_W-1:0] interp;
    always_comb
    begin
        interp_sum = a_reg * $signed({1'b0, 9'(9'd256 - {1'b0, frac})})
                   + rdata * $signed({2'b0, frac});
        interp     = SAMPLE_W'(interp_sum >>> FRAC_W);
    end

    // Divider step and sign fix
    logic signed [DIVD_W-1:0] div_in;
    logic [DIVD_W-1:0]        div_mag;
    logic [VCNT_W:0]          rem_sh;
    logic                     qbit;
    logic [VCNT_W-1:0]        rem_new;
    logic signed [DIVD_W-1:0] quo_fix;
    always_comb
    begin
        div_in  = $signed({side_reg ? sum_r_reg : sum_l_reg, 1'b0});
        div_mag = div_in[DIVD_W-1] ? DIVD_W'(-div_in) : DIVD_W'(div_in);
        rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
        qbit    = rem_sh >= {1'b0, n_eff};
        rem_new = qbit ? VCNT_W'(rem_sh - {1'b0, n_eff}) : VCNT_W'(rem_sh);
        if (neg_reg)
            quo_fix = -$signed(quo_reg + DIVD_W'(rem_reg != '0));
        else
            quo_fix = $signed(quo_reg);
    end

    // Dry/wet mix and saturation
    logic signed [16:0]         mix_s;
    logic signed [16:0]         inv_s;
    logic signed [MIX_W-1:0]    dry_prod;
    logic signed [MIX_W-1:0]    mix_total;
    logic signed [MIX_W-16:0]   mix_shift;
    logic signed [SAMPLE_W-1:0] mix_sat;
    always_comb
    begin
        mix_s     = $signed({1'b0, mix_eff});
        inv_s     = 17'sd32768 - mix_s;
        dry_prod  = MIX_W'((side_reg ? dry_r_reg : dry_l_reg) * inv_s);
        mix_total = dry_prod_reg + MIX_W'(wet_reg * mix_s);
        mix_shift = (MIX_W-15)'(mix_total >>> 15);
        if (mix_shift > SAT_MAX)
            mix_sat = SAMPLE_W'(SAT_MAX);
        else if (mix_shift < SAT_MIN)
            mix_sat = SAMPLE_W'(SAT_MIN);
        else
            mix_sat = SAMPLE_W'(mix_shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_dly_reg  <= 13'd720;
            mod_depth_reg   <= 12'd240;
            phase_step_reg  <= 32'd8948;
            wet_mix_reg     <= 16'd32768;
            voice_count_reg <= 5'd16;
            for (int v = 0; v < MAX_VOICE_TOTAL; v++)
                phase_reg[v] <= phase_init(v);
            vidx_reg      <= '0;
            wp_reg        <= '0;
            clr_addr_reg  <= '0;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_BASE_DELAY:  center_dly_reg  <= cfg_data[12:0];
                    REG_MOD_DEPTH:   mod_depth_reg   <= cfg_data[11:0];
                    REG_PHASE_STEP:  phase_step_reg  <= cfg_data;
                    REG_WET_MIX:     wet_mix_reg     <= cfg_data[15:0];
                    REG_VOICE_COUNT: voice_count_reg <= cfg_data[4:0];
                    default:         ;
                endcase
            end
            if (cmd.clr_wr)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cmd.line_wr)
            begin
                vidx_reg <= '0;
                side_reg <= 1'b0;
            end
            if (cmd.accum)
            begin
                phase_reg[vidx_reg] <= phase_reg[vidx_reg] + phase_step_reg;
                vidx_reg            <= vidx_reg + 1'b1;
            end
            if (cmd.div_ld)
                dcnt_reg <= DCNT_W'(DIVD_W - 1);
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg - 1'b1;
            if (cmd.side_next)
                side_reg <= 1'b1;
            // Hold the result until the sink takes it
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
                wp_reg        <= wp_reg + 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.line_wr)
        begin
            dry_l_reg <= in_data.in_left;
            dry_r_reg <= in_data.in_right;
            sum_l_reg <= '0;
            sum_r_reg <= '0;
        end
        if (cmd.sine_ld)
            sine_reg <= sine_val;
        if (cmd.dly_ld)
            dly_reg <= dly_clamp;
        if (cmd.rd_b)
            a_reg <= rdata;
        if (cmd.accum)
        begin
            if (vidx_reg[0])
                sum_r_reg <= sum_r_reg + SUM_W'(interp);
            else
                sum_l_reg <= sum_l_reg + SUM_W'(interp);
        end
        if (cmd.div_ld)
        begin
            neg_reg <= div_in[DIVD_W-1];
            quo_reg <= div_mag;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], qbit};
            rem_reg <= rem_new;
        end
        if (cmd.wet_ld)
        begin
            wet_reg      <= quo_fix;
            dry_prod_reg <= dry_prod;
        end
        if (cmd.mix_fin)
        begin
            if (side_reg)
                res_r_reg <= mix_sat;
            else
                res_l_reg <= mix_sat;
        end
        if (cmd.out_ld)
        begin
            out_data_reg.out_left  <= res_l_reg;
            out_data_reg.out_right <= res_r_reg;
        end
    end

    always_comb
    begin
        status.clear_done = &clr_addr_reg;
        status.last_voice = ({1'b0, vidx_reg} == VCNT_W'(n_eff - 1'b1));
        status.div_last   = (dcnt_reg == '0);
        status.side       = side_reg;
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/multi_voice_stereo_chorus.sv
// ----------------------------------------------------------------------------
// multi_voice_stereo_chorus
// Stereo chorus with up to sixteen sine-modulated voices reading two delay
// lines with linear interpolation. One item is handled at a time: the
// accepted pair is written into the two lines, each active voice then takes its
// phase, delay, two read and accumulate steps on the single port of its
// delay-line memory, each side's wet sum goes through a load and a
// bit-serial divider and then a sign-fix step and a mix step, and a last
// step loads the output register once it is free. A finished result waits
// in the output register while the next item is already taken. After reset
// both lines are cleared one entry a cycle while in_stall stays high;
// settings may be written meanwhile.
// ----------------------------------------------------------------------------
module multi_voice_stereo_chorus
    import mvc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mvc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mvc_out_t              out_data
);

    mvc_cmd_t    cmd;
    mvc_status_t status;

    mvc_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mvc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: rtl/mvc_chk.sv
// ----------------------------------------------------------------------------
// mvc_chk
// Port-level checks for the chorus, bound to the top level.
// ----------------------------------------------------------------------------
module mvc_chk
    import mvc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input mvc_out_t out_data
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // A result does not rise straight after its item is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind multi_voice_stereo_chorus mvc_chk u_mvc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
